FILE: src/zws_pkg.sv
// shared types and constants for the zncc window score block
package zws_pkg;

  localparam int unsigned MAX_WINDOW_PIXELS_DEF = 4096;
  localparam int unsigned SCORE_BITS = 16;
  localparam int unsigned SCALE_SHIFT = 30;

  typedef struct packed {
    logic [7:0] pixel_a;
    logic [7:0] pixel_b;
    logic       last_pixel;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic               defined;
    logic [12:0]        pixels_used;
  } out_beat_t;

  // multiplications run by the shared serial multiplier, in sequence order
  typedef enum logic [2:0] {
    MOP_NAA = 3'd0,
    MOP_AA  = 3'd1,
    MOP_NBB = 3'd2,
    MOP_BB  = 3'd3,
    MOP_NAB = 3'd4,
    MOP_AB  = 3'd5,
    MOP_VV  = 3'd6,
    MOP_CC  = 3'd7
  } mul_op_t;

  typedef struct packed {
    logic       acc_en;
    logic       mul_start;
    logic       mul_wb;
    mul_op_t    op;
    logic       srch_init;
    logic       srch_sum;
    logic       srch_upd;
    logic [3:0] bit_idx;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic var_zero;
    logic out_free;
  } sts_t;

endpackage

FILE: src/zws_ctrl.sv
// sequencer for accumulation, variance products and root search
module zws_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  zws_pkg::sts_t sts,
  output zws_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_MUL_START,
    ST_MUL_RUN,
    ST_CHECK,
    ST_SRCH_A,
    ST_SRCH_B,
    ST_OUT
  } state_t;

  state_t           state_r, state_nxt;
  zws_pkg::mul_op_t op_r, op_nxt;
  logic [3:0]       bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      op_r    <= zws_pkg::MOP_NAA;
      bit_r   <= 4'd15;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      bit_r   <= bit_nxt;
    end
  end

  assign in_ready = (state_r == ST_ACC);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    bit_nxt       = bit_r;
    cmd           = '0;
    cmd.op        = op_r;
    cmd.bit_idx   = bit_r;
    case (state_r)
      ST_ACC: begin
        if (in_valid) begin
          cmd.acc_en = 1'b1;
          if (in_last) begin
            op_nxt    = zws_pkg::MOP_NAA;
            state_nxt = ST_MUL_START;
          end
        end
      end
      ST_MUL_START: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        if (sts.mul_done) begin
          cmd.mul_wb = 1'b1;
          if (op_r == zws_pkg::MOP_CC) begin
            state_nxt = ST_CHECK;
          end else begin
            op_nxt    = zws_pkg::mul_op_t'(3'(op_r) + 3'd1);
            state_nxt = ST_MUL_START;
          end
        end
      end
      ST_CHECK: begin
        if (sts.var_zero) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.srch_init = 1'b1;
          bit_nxt       = 4'd15;
          state_nxt     = ST_SRCH_A;
        end
      end
      ST_SRCH_A: begin
        cmd.srch_sum = 1'b1;
        state_nxt    = ST_SRCH_B;
      end
      ST_SRCH_B: begin
        cmd.srch_upd = 1'b1;
        if (bit_r == 4'd0) begin
          state_nxt = ST_OUT;
        end else begin
          bit_nxt   = bit_r - 4'd1;
          state_nxt = ST_SRCH_A;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

endmodule

FILE: src/zws_dp.sv
// sums, serial multiplier, bitwise root search and output register
module zws_dp #(
  parameter int unsigned MAX_WINDOW_PIXELS = zws_pkg::MAX_WINDOW_PIXELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  zws_pkg::in_beat_t in_data,
  input  zws_pkg::cmd_t     cmd,
  output zws_pkg::sts_t     sts,
  output logic              out_valid,
  input  logic              out_ready,
  output zws_pkg::out_beat_t out_data
);

  localparam int unsigned CW  = $clog2(MAX_WINDOW_PIXELS + 1);
  localparam int unsigned SW  = CW + 8;
  localparam int unsigned QW  = CW + 16;
  localparam int unsigned VW  = CW + QW;
  localparam int unsigned PW  = 2 * VW;
  localparam int unsigned WW  = PW + 32;
  localparam int unsigned MCW = $clog2(VW + 1);

  logic [CW-1:0] n_r;
  logic [SW-1:0] sa_r, sb_r;
  logic [QW-1:0] saa_r, sbb_r, sab_r;
  logic [15:0]   aa, bb, ab;

  assign aa = {8'd0, in_data.pixel_a} * {8'd0, in_data.pixel_a};
  assign bb = {8'd0, in_data.pixel_b} * {8'd0, in_data.pixel_b};
  assign ab = {8'd0, in_data.pixel_a} * {8'd0, in_data.pixel_b};

  // count saturates at the window limit, further beats are dropped
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      n_r   <= '0;
      sa_r  <= '0;
      sb_r  <= '0;
      saa_r <= '0;
      sbb_r <= '0;
      sab_r <= '0;
    end else if (cmd.acc_en && (n_r < CW'(MAX_WINDOW_PIXELS))) begin
      n_r   <= n_r + CW'(1);
      sa_r  <= sa_r + SW'(in_data.pixel_a);
      sb_r  <= sb_r + SW'(in_data.pixel_b);
      saa_r <= saa_r + QW'(aa);
      sbb_r <= sbb_r + QW'(bb);
      sab_r <= sab_r + QW'(ab);
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  logic [VW-1:0]  opa, opb;
  logic [PW-1:0]  mcand_r, prod_r;
  logic [VW-1:0]  mplier_r;
  logic [MCW-1:0] mcnt_r;
  logic [VW-1:0]  t0_r, va_r, vb_r, c_r;
  logic           neg_r;
  logic [PW-1:0]  p_r;
  logic [WW-1:0]  r_r;
  logic [VW-1:0]  prod_lo;

  always_comb begin
    case (cmd.op)
      zws_pkg::MOP_NAA: begin opa = VW'(n_r);  opb = VW'(saa_r); end
      zws_pkg::MOP_AA:  begin opa = VW'(sa_r); opb = VW'(sa_r);  end
      zws_pkg::MOP_NBB: begin opa = VW'(n_r);  opb = VW'(sbb_r); end
      zws_pkg::MOP_BB:  begin opa = VW'(sb_r); opb = VW'(sb_r);  end
      zws_pkg::MOP_NAB: begin opa = VW'(n_r);  opb = VW'(sab_r); end
      zws_pkg::MOP_AB:  begin opa = VW'(sa_r); opb = VW'(sb_r);  end
      zws_pkg::MOP_VV:  begin opa = va_r;      opb = vb_r;       end
      zws_pkg::MOP_CC:  begin opa = c_r;       opb = c_r;        end
      default:          begin opa = '0;        opb = '0;         end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= '0;
    end else if (cmd.mul_start) begin
      mcnt_r <= MCW'(VW);
    end else if (mcnt_r != '0) begin
      mcnt_r <= mcnt_r - MCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mcand_r  <= PW'(opa);
      mplier_r <= opb;
      prod_r   <= '0;
    end else if (mcnt_r != '0) begin
      if (mplier_r[0]) begin
        prod_r <= prod_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign prod_lo = prod_r[VW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_wb) begin
      case (cmd.op)
        zws_pkg::MOP_NAA: t0_r <= prod_lo;
        zws_pkg::MOP_AA:  va_r <= t0_r - prod_lo;
        zws_pkg::MOP_NBB: t0_r <= prod_lo;
        zws_pkg::MOP_BB:  vb_r <= t0_r - prod_lo;
        zws_pkg::MOP_NAB: t0_r <= prod_lo;
        zws_pkg::MOP_AB: begin
          neg_r <= (t0_r < prod_lo);
          c_r   <= (t0_r < prod_lo) ? (prod_lo - t0_r) : (t0_r - prod_lo);
        end
        zws_pkg::MOP_VV:  p_r <= prod_r;
        zws_pkg::MOP_CC:  r_r <= WW'(prod_r) << zws_pkg::SCALE_SHIFT;
        default:          t0_r <= t0_r;
      endcase
    end
  end

  // largest m with p*m*m <= c*c*2^30, one bit per sum state and update state
  // q = p*m^2, s = p*m<<(k+1), t = p<<2k
  logic [WW-1:0] q_r, s_r, t_r, trial_r;
  logic [15:0]   m_r;

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      q_r <= '0;
      s_r <= '0;
      t_r <= WW'(p_r) << zws_pkg::SCALE_SHIFT;
      m_r <= '0;
    end else if (cmd.srch_sum) begin
      trial_r <= q_r + s_r + t_r;
    end else if (cmd.srch_upd) begin
      if (trial_r <= r_r) begin
        q_r              <= trial_r;
        s_r              <= (s_r >> 1) + t_r;
        m_r[cmd.bit_idx] <= 1'b1;
      end else begin
        s_r <= s_r >> 1;
      end
      t_r <= t_r >> 2;
    end
  end

  logic               var_zero;
  logic signed [15:0] score;
  logic [31:0]        n_wide;

  assign var_zero = (va_r == '0) || (vb_r == '0);
  assign n_wide   = 32'(n_r);

  always_comb begin
    if (var_zero) begin
      score = '0;
    end else if (neg_r) begin
      score = -$signed(m_r);
    end else if (m_r[15]) begin
      score = 16'sh7fff;
    end else begin
      score = $signed(m_r);
    end
  end

  logic               out_valid_r;
  zws_pkg::out_beat_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.score       <= score;
      out_data_r.defined     <= ~var_zero;
      out_data_r.pixels_used <= n_wide[12:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.mul_done = (mcnt_r == '0);
  assign sts.var_zero = var_zero;
  assign sts.out_free = ~out_valid_r | out_ready;

endmodule

FILE: src/zncc_window_score.sv
// top level of the zero-mean normalised cross-correlation window scorer
// Pixel pairs are taken one per cycle while a window is summed. After the beat
// flagged last_pixel, in_ready drops while one shared shift-add multiplier
// forms the eight products behind the variances and covariance (operands
// VW = 2*clog2(MAX_WINDOW_PIXELS+1)+16 bits wide) and, unless a variance is
// zero, a bitwise root search settles the 16 score bits one at a time. The
// result waits in an output register, so the next window starts summing while
// it is still held.
module zncc_window_score #(
  parameter int unsigned MAX_WINDOW_PIXELS = zws_pkg::MAX_WINDOW_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  zws_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output zws_pkg::out_beat_t out_data
);

  zws_pkg::cmd_t cmd;
  zws_pkg::sts_t sts;

  zws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_pixel),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  zws_dp #(
    .MAX_WINDOW_PIXELS (MAX_WINDOW_PIXELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/zws_checker.sv
// port-level checks for the window scorer, bound to the top level
module zws_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input zws_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input zws_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result beat changed while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_pixel |=> !in_ready)
    else $error("input taken while a window is being scored");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.defined |-> out_data.score == 16'sd0)
    else $error("undefined score is not zero");

endmodule

bind zncc_window_score zws_checker u_zws_checker (.*);

FILE: tb/sv/tb_zncc_window_score.sv
// testbench for the zncc window scorer: directed rows, random windows, scoreboard
`timescale 1ns / 1ps

module tb_zncc_window_score;

  localparam int unsigned WIN_MAX = zws_pkg::MAX_WINDOW_PIXELS_DEF;

  typedef struct {
    logic [7:0]   pa;
    logic [7:0]   pb;
    logic         last;
    bit           typed;
    logic [15:0]  score;
    logic         defined;
    logic [12:0]  used;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  zws_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  zws_pkg::out_beat_t out_data;

  zws_pkg::out_beat_t score_q[$];
  int unsigned err_count = 0;
  int unsigned beats_sent = 0;
  int unsigned windows_seen = 0;
  bit          draining = 1'b0;

  // running window sums of the predictor
  logic [63:0] acc_a, acc_b, acc_aa, acc_bb, acc_ab;
  logic [31:0] acc_n;

  zncc_window_score u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic zws_pkg::out_beat_t close_window();
    zws_pkg::out_beat_t r;
    logic [63:0] n, var_a, var_b, pos, neg, c;
    logic [127:0] prod, c2, rhs, lhs;
    int unsigned lo, hi, mid;
    bit          negative;
    n = acc_n;
    var_a = n * acc_aa - acc_a * acc_a;
    var_b = n * acc_bb - acc_b * acc_b;
    pos = n * acc_ab;
    neg = acc_a * acc_b;
    negative = pos < neg;
    c = negative ? neg - pos : pos - neg;
    r = '0;
    if (var_a != 0 && var_b != 0) begin
      prod = 128'(var_a) * 128'(var_b);
      c2 = 128'(c) * 128'(c);
      rhs = c2 << zws_pkg::SCALE_SHIFT;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = prod * 128'(mid * mid);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (negative) r.score = 16'(-int'(lo));
      else r.score = (lo > 32767) ? 16'sd32767 : 16'(lo);
      r.defined = 1'b1;
    end
    r.pixels_used = n[12:0];
    return r;
  endfunction

  // advances the window sums; returns 1 with the score on a closing beat
  function automatic bit take_pair(input zws_pkg::in_beat_t b,
                                   output zws_pkg::out_beat_t r);
    r = '0;
    if (acc_n < WIN_MAX) begin
      acc_a += b.pixel_a;
      acc_b += b.pixel_b;
      acc_aa += b.pixel_a * b.pixel_a;
      acc_bb += b.pixel_b * b.pixel_b;
      acc_ab += b.pixel_a * b.pixel_b;
      acc_n += 1;
    end
    if (!b.last_pixel) return 1'b0;
    r = close_window();
    {acc_a, acc_b, acc_aa, acc_bb, acc_ab, acc_n} = '0;
    return 1'b1;
  endfunction

  task automatic send_pair(input zws_pkg::in_beat_t b, input bit typed,
                           input zws_pkg::out_beat_t typed_res);
    zws_pkg::out_beat_t res;
    zws_pkg::out_beat_t exp_beat;
    int unsigned r, gap;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (take_pair(b, res)) begin
      exp_beat = typed ? typed_res : res;
      score_q.insert(score_q.size(), exp_beat);
    end
    r = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver stalls: mostly ready, short holds, the odd long one
  initial begin
    int unsigned r;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (draining || r < 55) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (r < 92) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    zws_pkg::out_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      windows_seen++;
      if (score_q.size() == 0) begin
        $error("score beat with none expected: %h", out_data);
        err_count++;
      end else begin
        e = score_q.pop_front();
        if (out_data.score !== e.score) begin
          $error("score: expected %0d, got %0d", $signed(e.score), $signed(out_data.score));
          err_count++;
        end
        if (out_data.defined !== e.defined) begin
          $error("defined: expected %0d, got %0d", e.defined, out_data.defined);
          err_count++;
        end
        if (out_data.pixels_used !== e.pixels_used) begin
          $error("pixels_used: expected %0d, got %0d", e.pixels_used, out_data.pixels_used);
          err_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    zws_pkg::in_beat_t  b;
    zws_pkg::out_beat_t t;
    int unsigned len, mode, k, base, wait_cnt;
    {acc_a, acc_b, acc_aa, acc_bb, acc_ab, acc_n} = '0;

    // single pair, perfect match, perfect opposite, flat windows, then mixed
    rows = '{
      '{8'd10, 8'd20, 1'b1, 1, 16'd0, 1'b0, 13'd1},
      '{8'd0, 8'd0, 1'b0, 0, 16'd0, 1'b0, 13'd0},
      '{8'd255, 8'd255, 1'b1, 1, 16'h7fff, 1'b1, 13'd2},
      '{8'd0, 8'd255, 1'b0, 0, 16'd0, 1'b0, 13'd0},
      '{8'd255, 8'd0, 1'b1, 1, 16'h8000, 1'b1, 13'd2},
      '{8'd5, 8'd7, 1'b0, 0, 16'd0, 1'b0, 13'd0},
      '{8'd9, 8'd7, 1'b1, 1, 16'd0, 1'b0, 13'd2},
      '{8'd0, 8'd0, 1'b0, 0, 16'd0, 1'b0, 13'd0},
      '{8'd0, 8'd0, 1'b1, 1, 16'd0, 1'b0, 13'd2},
      '{8'd1, 8'd200, 1'b0, 0, 16'd0, 1'b0, 13'd0},
      '{8'd128, 8'd3, 1'b0, 0, 16'd0, 1'b0, 13'd0},
      '{8'd77, 8'd77, 1'b0, 0, 16'd0, 1'b0, 13'd0},
      '{8'd200, 8'd199, 1'b0, 0, 16'd0, 1'b0, 13'd0},
      '{8'd255, 8'd1, 1'b1, 0, 16'd0, 1'b0, 13'd0},
      '{8'd255, 8'd255, 1'b0, 0, 16'd0, 1'b0, 13'd0},
      '{8'd255, 8'd17, 1'b0, 0, 16'd0, 1'b0, 13'd0},
      '{8'd255, 8'd254, 1'b1, 1, 16'd0, 1'b0, 13'd3}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      b = '{pixel_a: row.pa, pixel_b: row.pb, last_pixel: row.last};
      t = '{score: row.score, defined: row.defined, pixels_used: row.used};
      send_pair(b, row.typed, t);
    end

    // random windows: mostly short, some long
    while (beats_sent < 1450) begin
      k = $urandom_range(0, 99);
      if (k < 8) len = 1;
      else if (k < 90) len = $urandom_range(2, 24);
      else len = $urandom_range(60, 250);
      mode = $urandom_range(0, 5);
      base = $urandom_range(0, 255);
      for (int unsigned p = 0; p < len; p++) begin
        b.pixel_a = $urandom_range(0, 255);
        case (mode)
          0, 1: b.pixel_b = $urandom_range(0, 255);
          2: b.pixel_b = 8'(b.pixel_a + $urandom_range(0, 6));
          3: b.pixel_b = ~b.pixel_a;
          4: b.pixel_b = 8'(base);
          default: begin
            b.pixel_a = 8'(base);
            b.pixel_b = $urandom_range(0, 255);
          end
        endcase
        b.last_pixel = (p == len - 1);
        send_pair(b, 1'b0, t);
      end
    end

    in_valid <= 1'b0;
    draining = 1'b1;
    wait_cnt = 0;
    while (score_q.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (400) @(posedge clk);
    $display("covered %0d pixel pairs over %0d scored windows, incl. flat, opposite and",
             beats_sent, windows_seen);
    $display("long windows, with random stalls on both channels");
    if (err_count == 0 && score_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
